FILE: rtl/core/ifup_pkg.sv
// Shared constants, codes and types of the integer factor image upscaler.
package ifup_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int MAX_FACTOR_DEF = 8;

    // Fixed field and register widths.
    localparam int COORD_BITS      = 13;
    localparam int ROW_BITS        = 10;
    localparam int FACTOR_REG_BITS = 4;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_BITS = 4;

    // Register values after reset.
    localparam logic [FACTOR_REG_BITS-1:0] FACTOR_RESET = 4'd2;
    localparam logic                       MODE_RESET   = 1'b1;
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;

    // Interpolation modes.
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_SCALE = 2'd0,
        REG_MODE  = 2'd1,
        REG_WIDTH = 2'd2
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Sideband of one output pixel, carried alongside the datapath.
    typedef struct packed {
        logic                  last;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } side_t;

endpackage

FILE: rtl/core/ifup_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ifup_ram #(
    parameter int  WIDTH = ifup_pkg::PIXEL_BITS_DEF,
    parameter int  DEPTH = ifup_pkg::MAX_WIDTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/ifup_interp.sv
// Pipelined weighting, rounding and division datapath of the upscaler.
module ifup_interp #(
    parameter int  PIXEL_BITS = ifup_pkg::PIXEL_BITS_DEF,
    parameter int  MAX_FACTOR = ifup_pkg::MAX_FACTOR_DEF,
    localparam int WTW        = $clog2(MAX_FACTOR * MAX_FACTOR + 1),
    localparam int DW         = $clog2(2 * MAX_FACTOR * MAX_FACTOR + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  ifup_pkg::side_t             in_side,
    input  logic [3:0][PIXEL_BITS-1:0]  in_pix,
    input  logic [3:0][WTW-1:0]         in_wt,
    input  logic [WTW-1:0]              in_rnd,
    input  logic [DW-1:0]               in_div,
    output logic                        out_valid,
    output logic [PIXEL_BITS-1:0]       out_value,
    output ifup_pkg::side_t             out_side
);

    import ifup_pkg::*;

    localparam int SW  = PIXEL_BITS + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int NW  = SW + 1;
    localparam int NDS = (PIXEL_BITS + DIV_BITS - 1) / DIV_BITS;

    // Stage A: operands.
    logic                       a_vld_reg;
    side_t                      a_side_reg;
    logic [3:0][PIXEL_BITS-1:0] a_pix_reg;
    logic [3:0][WTW-1:0]        a_wt_reg;
    logic [WTW-1:0]             a_rnd_reg;
    logic [DW-1:0]              a_div_reg;

    // Stage B: weighted neighbours.
    logic                       b_vld_reg;
    side_t                      b_side_reg;
    logic [3:0][SW-1:0]         b_prod_reg;
    logic [WTW-1:0]             b_rnd_reg;
    logic [DW-1:0]              b_div_reg;

    // Divider stages; index 0 holds the freshly formed numerator.
    logic                       vld_reg  [NDS+1];
    side_t                      side_reg [NDS+1];
    logic [DW-1:0]              div_reg  [NDS+1];
    logic [DW-1:0]              rem_reg  [NDS+1];
    logic [PIXEL_BITS-1:0]      num_reg  [NDS+1];
    logic [DW-1:0]              rem_next [NDS+1];
    logic [PIXEL_BITS-1:0]      num_next [NDS+1];

    logic [NW-1:0]              sum_c;
    logic [NW-1:0]              numer_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            for (int s = 0; s <= NDS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg  <= in_valid;
            b_vld_reg  <= a_vld_reg;
            vld_reg[0] <= b_vld_reg;
            for (int s = 0; s < NDS; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    // Numerator 2*S + rounding term; the quotient always fits the pixel width,
    // so the bits above it already form a remainder below the divisor.
    // Restoring long division follows, a few quotient bits per stage. Quotient
    // bits shift in at the bottom of the numerator word as its bits shift out.
    always_comb
    begin
        logic [DW:0]           trial;
        logic [DW-1:0]         rem_w;
        logic [PIXEL_BITS-1:0] num_w;
        sum_c = NW'(b_prod_reg[0]) + NW'(b_prod_reg[1])
              + NW'(b_prod_reg[2]) + NW'(b_prod_reg[3]);
        numer_c = (sum_c << 1) + NW'(b_rnd_reg);
        rem_next[0] = DW'(numer_c[NW-1:PIXEL_BITS]);
        num_next[0] = numer_c[PIXEL_BITS-1:0];
        trial = '0;
        rem_w = '0;
        num_w = '0;
        for (int s = 0; s < NDS; s++)
        begin
            rem_w = rem_reg[s];
            num_w = num_reg[s];
            for (int k = 0; k < DIV_BITS; k++)
            begin
                if (s * DIV_BITS + k < PIXEL_BITS)
                begin
                    trial = {rem_w, num_w[PIXEL_BITS-1]};
                    num_w = {num_w[PIXEL_BITS-2:0], 1'b0};
                    if (trial >= {1'b0, div_reg[s]})
                    begin
                        trial    = trial - {1'b0, div_reg[s]};
                        num_w[0] = 1'b1;
                    end
                    rem_w = trial[DW-1:0];
                end
            end
            rem_next[s+1] = rem_w;
            num_next[s+1] = num_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= in_side;
            a_pix_reg  <= in_pix;
            a_wt_reg   <= in_wt;
            a_rnd_reg  <= in_rnd;
            a_div_reg  <= in_div;

            b_side_reg <= a_side_reg;
            b_rnd_reg  <= a_rnd_reg;
            b_div_reg  <= a_div_reg;
            for (int k = 0; k < 4; k++)
            begin
                b_prod_reg[k] <= SW'(a_pix_reg[k]) * SW'(a_wt_reg[k]);
            end

            side_reg[0] <= b_side_reg;
            div_reg[0]  <= b_div_reg;
            for (int s = 0; s <= NDS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
            end
            for (int s = 0; s < NDS; s++)
            begin
                side_reg[s+1] <= side_reg[s];
                div_reg[s+1]  <= div_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NDS];
    assign out_value = num_reg[NDS];
    assign out_side  = side_reg[NDS];

    a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (div_reg[0] != '0))
        else $error("divisor is zero at the divider input");

    a_quot_fits : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (rem_reg[0] < div_reg[0]))
        else $error("quotient would overflow the pixel width");

    a_rem_final : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rem_reg[NDS] < div_reg[NDS]))
        else $error("final remainder not below divisor");

endmodule

FILE: rtl/core/integer_factor_image_upscaler_core.sv
// Top level of the integer factor image upscaler: sequencer, line store and register port.
//
// Source pixels enter on the s_ channel in raster order, one transfer per pixel;
// s_tuser[0] marks the first pixel of a frame and restarts the position count.
// Every pixel at source row r >= 1 and column c >= 1 produces a factor-by-factor
// tile of output pixels on the m_ channel, in raster order within the tile, each
// with its output row and column; m_tlast flags the last pixel of the tile.
// Pixels in row 0 or column 0 produce nothing.
// The previous source row lives in a RAM with a registered read port: a pixel is
// taken in one cycle, its upper neighbour arrives and is replaced in the next,
// and then the tile is issued at one output pixel per cycle while the output does
// not stall. The input takes no new pixel until the sequencer is back in idle; the
// tile sequencer is the limit. The first output pixel of a tile passes from the input
// transfer through the fetch state, the tile setup registers, operand stage A,
// weighting stage B and the long-division stages.
// When the receiver holds m_tready low while m_tvalid is high, the whole output
// pipeline stalls and the tile sequencer waits; nothing is dropped.
// Reset clears the position, the left and upper-left neighbours and sets the
// registers to factor 2, bilinear mode and width 640. The line store is not
// cleared: values read in row 0 go unused, and later rows read what the row above wrote.
// Registers (APB, 32-bit data): 0x0 scale_factor, 0x4 interp_mode, 0x8 image_width.
module integer_factor_image_upscaler_core #(
    parameter int MAX_WIDTH  = ifup_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = ifup_pkg::PIXEL_BITS_DEF,
    parameter int MAX_FACTOR = ifup_pkg::MAX_FACTOR_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // Input stream.
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // s_tdata: pixel_value
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]            s_tdata,
    // s_tuser: frame_start
    input  logic [0:0]                                 s_tuser,
    // Output stream.
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // m_tdata: out_value, out_row, out_col, zero padding
    output logic [((PIXEL_BITS+2*ifup_pkg::COORD_BITS+7)/8)*8-1:0] m_tdata,
    // m_tlast: tile_last
    output logic                                       m_tlast,
    // Register port.
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [ifup_pkg::APB_ADDR_BITS-1:0]         paddr,
    input  logic [ifup_pkg::APB_DATA_BITS-1:0]         pwdata,
    output logic [ifup_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);

    import ifup_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (WIDTH_REG_BITS > CW + 1) ? WIDTH_REG_BITS : CW + 1;
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int DXW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int WTW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DW   = $clog2(2 * MAX_FACTOR * MAX_FACTOR + 1);
    localparam int TDW  = ((PIXEL_BITS + 2 * COORD_BITS + 7) / 8) * 8;

    // Configuration registers.
    logic [FACTOR_REG_BITS-1:0] scale_reg;
    logic                       mode_reg;
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic                       cfg_wr;

    // Sequencer.
    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   gen_valid;
    logic   gen_last;
    logic   adv;

    // Position and neighbour state.
    logic [CW-1:0]         col_count_reg;
    logic [ROW_BITS-1:0]   row_count_reg;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] ul_reg;
    logic [CW-1:0]         col_sel;
    logic [ROW_BITS-1:0]   row_sel;

    // Pixel held between its transfer and the line store read.
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [CW-1:0]         c_reg;
    logic [ROW_BITS-1:0]   r_reg;
    logic [PIXEL_BITS-1:0] up_data;

    // Tile being issued.
    logic [3:0][PIXEL_BITS-1:0] tile_reg;
    logic [FW-1:0]              f_reg;
    logic                       tmode_reg;
    logic [COORD_BITS-1:0]      base_r_reg;
    logic [COORD_BITS-1:0]      base_c_reg;
    logic [DXW-1:0]             dx_reg;
    logic [DXW-1:0]             dy_reg;

    // Clamped configuration and per-pixel decisions.
    logic [FW-1:0]          f_cl;
    logic [CMPW-1:0]        w_cl;
    logic                   wrap;
    logic                   emit;
    logic [ROW_BITS-1:0]    r_m1;
    logic [CW-1:0]          c_m1;
    logic [ROW_BITS+FW-1:0] base_r_full;
    logic [CW+FW-1:0]       base_c_full;

    // Generator outputs.
    logic                  dx_end;
    logic [FW-1:0]         fmdx;
    logic [FW-1:0]         fmdy;
    logic                  right;
    logic                  down;
    logic [2*FW-1:0]       ff;
    logic [3:0][WTW-1:0]   gen_wt;
    logic [WTW-1:0]        gen_rnd;
    logic [DW-1:0]         gen_div;
    side_t                 gen_side;

    // Pipeline output.
    logic [PIXEL_BITS-1:0] out_value;
    side_t                 out_side;

    // ------------------------------------------------------------------
    // Register port. Writes land in the access phase; reads are decoded
    // combinationally, so pready stays high.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= FACTOR_RESET;
            mode_reg  <= MODE_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_SCALE: scale_reg <= pwdata[FACTOR_REG_BITS-1:0];
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_WIDTH: width_reg <= pwdata[WIDTH_REG_BITS-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_SCALE: prdata = APB_DATA_BITS'(scale_reg);
            REG_MODE:  prdata = APB_DATA_BITS'(mode_reg);
            REG_WIDTH: prdata = APB_DATA_BITS'(width_reg);
            default:   prdata = '0;
        endcase
    end

    // Out-of-range settings are pulled to the nearest legal value.
    always_comb
    begin
        if (scale_reg == '0)
        begin
            f_cl = FW'(1);
        end
        else if (scale_reg > FACTOR_REG_BITS'(MAX_FACTOR))
        begin
            f_cl = FW'(MAX_FACTOR);
        end
        else
        begin
            f_cl = FW'(scale_reg);
        end

        if (CMPW'(width_reg) < CMPW'(2))
        begin
            w_cl = CMPW'(2);
        end
        else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH))
        begin
            w_cl = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_cl = CMPW'(width_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: take a pixel, fetch its upper neighbour, issue the tile.
    // ------------------------------------------------------------------
    assign adv     = !m_tvalid || m_tready;
    assign in_xfer = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        gen_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                gen_valid = 1'b1;
                if (adv && gen_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A frame start restarts the position before the pixel is used.
    assign col_sel = s_tuser[0] ? '0 : col_count_reg;
    assign row_sel = s_tuser[0] ? '0 : row_count_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= s_tdata[PIXEL_BITS-1:0];
            c_reg   <= col_sel;
            r_reg   <= row_sel;
        end
    end

    // The line store is read as the pixel is taken and overwritten with it
    // in the following cycle, so a read never meets a pending write.
    ifup_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (state_reg == ST_FETCH),
        .wr_addr (c_reg),
        .wr_data (pix_reg),
        .rd_en   (in_xfer),
        .rd_addr (col_sel),
        .rd_data (up_data)
    );

    assign wrap        = (CMPW'(c_reg) + CMPW'(1)) >= w_cl;
    assign emit        = (r_reg != '0) && (c_reg != '0);
    assign r_m1        = r_reg - ROW_BITS'(1);
    assign c_m1        = c_reg - CW'(1);
    assign base_r_full = (ROW_BITS+FW)'(r_m1) * (ROW_BITS+FW)'(f_cl);
    assign base_c_full = (CW+FW)'(c_m1) * (CW+FW)'(f_cl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
        end
        else if (state_reg == ST_FETCH)
        begin
            left_reg      <= pix_reg;
            ul_reg        <= up_data;
            col_count_reg <= wrap ? '0 : c_reg + CW'(1);
            row_count_reg <= wrap ? r_reg + ROW_BITS'(1) : r_reg;
        end
    end

    // Tile setup: the four neighbours are upper-left, upper, left, current.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            tile_reg[0] <= ul_reg;
            tile_reg[1] <= up_data;
            tile_reg[2] <= left_reg;
            tile_reg[3] <= pix_reg;
            f_reg       <= f_cl;
            tmode_reg   <= mode_reg;
            base_r_reg  <= COORD_BITS'(base_r_full);
            base_c_reg  <= COORD_BITS'(base_c_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg <= '0;
            dy_reg <= '0;
        end
        else if (state_reg == ST_FETCH)
        begin
            dx_reg <= '0;
            dy_reg <= '0;
        end
        else if (gen_valid && adv)
        begin
            if (dx_end)
            begin
                dx_reg <= '0;
                dy_reg <= dy_reg + DXW'(1);
            end
            else
            begin
                dx_reg <= dx_reg + DXW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Weights of the current tile pixel. In bilinear mode they are the
    // area products; in nearest mode one neighbour gets weight one, and the
    // rounding term and divisor are chosen so the quotient is that pixel.
    // ------------------------------------------------------------------
    assign dx_end   = FW'(dx_reg) == (f_reg - FW'(1));
    assign gen_last = dx_end && (FW'(dy_reg) == (f_reg - FW'(1)));
    assign fmdx     = f_reg - FW'(dx_reg);
    assign fmdy     = f_reg - FW'(dy_reg);
    assign right    = (FW+1)'({dx_reg, 1'b0}) >= (FW+1)'(f_reg);
    assign down     = (FW+1)'({dy_reg, 1'b0}) >= (FW+1)'(f_reg);
    assign ff       = (2*FW)'(f_reg) * (2*FW)'(f_reg);

    always_comb
    begin
        if (tmode_reg == MODE_BILINEAR)
        begin
            gen_wt[0] = WTW'((2*FW)'(fmdx) * (2*FW)'(fmdy));
            gen_wt[1] = WTW'((2*FW)'(dx_reg) * (2*FW)'(fmdy));
            gen_wt[2] = WTW'((2*FW)'(fmdx) * (2*FW)'(dy_reg));
            gen_wt[3] = WTW'((2*FW)'(dx_reg) * (2*FW)'(dy_reg));
            gen_rnd   = WTW'(ff);
            gen_div   = DW'({ff, 1'b0});
        end
        else
        begin
            gen_wt[0] = WTW'(!right && !down);
            gen_wt[1] = WTW'(right && !down);
            gen_wt[2] = WTW'(!right && down);
            gen_wt[3] = WTW'(right && down);
            gen_rnd   = '0;
            gen_div   = DW'(2);
        end
        gen_side.row  = base_r_reg + COORD_BITS'(dy_reg);
        gen_side.col  = base_c_reg + COORD_BITS'(dx_reg);
        gen_side.last = gen_last;
    end

    ifup_interp #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (gen_valid),
        .in_side   (gen_side),
        .in_pix    (tile_reg),
        .in_wt     (gen_wt),
        .in_rnd    (gen_rnd),
        .in_div    (gen_div),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_side  (out_side)
    );

    assign m_tdata = TDW'({out_side.col, out_side.row, out_value});
    assign m_tlast = out_side.last;

    a_fetch_follows : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_FETCH))
        else $error("pixel transfer not followed by line store fetch");

    a_tile_done : assert property (@(posedge clk) disable iff (!rst_n)
        (gen_valid && adv && gen_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the tile");

    a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= CW'(MAX_WIDTH - 1))
        else $error("column count beyond the line store");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the integer factor image upscaler core, stream and register ports.
module testbench;
    import ifup_pkg::*;

    // Field positions and sizes of the two streams.
    localparam int PIX_W    = PIXEL_BITS_DEF;
    localparam int S_DATA_W = ((PIX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((PIX_W + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int ROW_LSB  = PIX_W;
    localparam int COL_LSB  = PIX_W + COORD_BITS;

    // TILE_LATENCY covers the path from the transfer in to the first output pixel of a
    // tile, the fetch of the upper neighbour included, with a margin added. The settling
    // pause is longer than that, so that a pixel which produces nothing has certainly
    // left the block before the registers are touched.
    localparam int TILE_LATENCY  = 6 + (PIX_W + DIV_BITS - 1) / DIV_BITS;
    localparam int SETTLE_CYCLES = 3 * TILE_LATENCY;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_SHOWN   = 10;

    // One output pixel as the predictor expects it.
    typedef struct packed {
        logic [PIX_W-1:0]      value;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } out_px_t;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_DATA_W-1:0]       s_tdata  = '0;
    logic [0:0]                s_tuser  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_DATA_W-1:0]       m_tdata;
    logic                      m_tlast;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr    = '0;
    logic [APB_DATA_BITS-1:0]  pwdata   = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // Percentage of cycles in which the sender and the receiver hold back.
    int src_idle = 0;
    int snk_idle = 0;

    // Predictor copy of the registers and of the block's state.
    logic [FACTOR_REG_BITS-1:0] cfg_factor = FACTOR_RESET;
    logic                       cfg_mode   = MODE_RESET;
    logic [WIDTH_REG_BITS-1:0]  cfg_width  = WIDTH_RESET;
    logic [PIX_W-1:0]           prev_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]           left_pix   = '0;
    logic [PIX_W-1:0]           upleft_pix = '0;
    int unsigned                col_pos    = 0;
    int unsigned                row_pos    = 0;

    // Output pixels predicted but not yet seen, oldest first.
    out_px_t pending_px[$];
    int      mismatches = 0;

    integer_factor_image_upscaler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Only the first few mismatches are shown in full; the rest are merely counted.
    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    // One weighted output value. Nearest mode picks the lower or right neighbour once
    // twice the offset reaches the factor. Bilinear mode sums the four neighbours with
    // integer weights and divides by factor squared, rounding halves upwards.
    function automatic logic [PIX_W-1:0] tile_value(input logic [PIX_W-1:0] tl,
                                                    input logic [PIX_W-1:0] tr,
                                                    input logic [PIX_W-1:0] bl,
                                                    input logic [PIX_W-1:0] br,
                                                    input int unsigned f,
                                                    input int unsigned dx,
                                                    input int unsigned dy,
                                                    input logic mode);
        longint unsigned wx0, wx1, wy0, wy1, acc, area;
        if (mode == MODE_NEAREST)
        begin
            if (2 * dy >= f)
                return (2 * dx >= f) ? br : bl;
            return (2 * dx >= f) ? tr : tl;
        end
        wx0  = f - dx;
        wx1  = dx;
        wy0  = f - dy;
        wy1  = dy;
        acc  = tl * wx0 * wy0 + tr * wx1 * wy0 + bl * wx0 * wy1 + br * wx1 * wy1;
        area = wx0 + wx1;
        area = area * area;
        return PIX_W'((2 * acc + area) / (2 * area));
    endfunction

    // Advances the predictor by one accepted source pixel and queues the tile it closes.
    function automatic void predict_tile(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned f, w, c, r, dy, dx;
        logic [PIX_W-1:0] up;
        out_px_t px;
        f = cfg_factor;
        if (f < 1)
            f = 1;
        if (f > MAX_FACTOR_DEF)
            f = MAX_FACTOR_DEF;
        w = cfg_width;
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c  = col_pos;
        r  = row_pos;
        up = prev_line[c];
        if (r >= 1 && c >= 1)
        begin
            for (dy = 0; dy < f; dy++)
            begin
                for (dx = 0; dx < f; dx++)
                begin
                    px.value = tile_value(upleft_pix, up, left_pix, pix, f, dx, dy, cfg_mode);
                    px.row   = COORD_BITS'((r - 1) * f + dy);
                    px.col   = COORD_BITS'((c - 1) * f + dx);
                    px.last  = (dy == f - 1) && (dx == f - 1);
                    pending_px.push_back(px);
                end
            end
        end
        upleft_pix   = up;
        left_pix     = pix;
        prev_line[c] = pix;
        // A column that reaches the width, even one lowered in mid-row, starts a new row.
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1) % (1 << ROW_BITS);
        end
        else
            col_pos = c + 1;
    endfunction

    function automatic logic [APB_DATA_BITS-1:0] reg_mask(input reg_idx_t idx);
        case (idx)
            REG_SCALE: return (1 << FACTOR_REG_BITS) - 1;
            REG_MODE:  return 1;
            REG_WIDTH: return (1 << WIDTH_REG_BITS) - 1;
            default:   return '0;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return PIX_W'($urandom);
    endfunction

    // Reads a register back and compares the bits it holds, then leaves the bus idle.
    task automatic check_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] want);
        logic [APB_DATA_BITS-1:0] mask;
        mask = reg_mask(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((prdata & mask) !== (want & mask))
            report_mismatch("register read", 64'(want & mask), 64'(prdata & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes a register, mirrors it in the predictor and reads it back. The read
    // follows straight on, so the select is left high in between.
    task automatic program_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value & reg_mask(idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SCALE: cfg_factor = value[FACTOR_REG_BITS-1:0];
            REG_MODE:  cfg_mode   = value[0];
            REG_WIDTH: cfg_width  = value[WIDTH_REG_BITS-1:0];
            default:   ;
        endcase
        check_reg(idx, value);
    endtask

    // Offers one source pixel, after a random hold-off, and predicts its tile once the
    // transfer has taken place. The valid stays high on return, so that a following
    // pixel may go out back to back; every other path lowers it first.
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while (src_idle > 0 && $urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(pix);
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tile(pix, fs);
    endtask

    // Stops the source and waits until every predicted pixel has come out.
    task automatic wait_for_tiles();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // The registers must come out of reset with their documented values.
    task automatic test_register_reset();
        check_reg(REG_SCALE, FACTOR_RESET);
        check_reg(REG_MODE, MODE_RESET);
        check_reg(REG_WIDTH, WIDTH_RESET);
    endtask

    // Black and full-scale pixels in a checkerboard, with the reset factor and mode.
    task automatic test_corner_pixels();
        program_reg(REG_WIDTH, 3);
        push_pixel('0, 1'b1);
        push_pixel('1, 1'b0);
        push_pixel('0, 1'b0);
        push_pixel('1, 1'b0);
        push_pixel('0, 1'b0);
        push_pixel('1, 1'b0);
        wait_for_tiles();
    endtask

    // Factor and width outside their ranges fall back to the nearest legal value; an
    // odd factor exercises the rounding of halves in bilinear mode.
    task automatic test_factor_limits();
        program_reg(REG_MODE, MODE_NEAREST);
        program_reg(REG_SCALE, (1 << FACTOR_REG_BITS) - 1);
        program_reg(REG_WIDTH, 1);
        push_pixel('1, 1'b1);
        push_pixel('0, 1'b0);
        push_pixel('0, 1'b0);
        push_pixel('1, 1'b0);
        wait_for_tiles();
        program_reg(REG_SCALE, 0);
        program_reg(REG_MODE, MODE_BILINEAR);
        program_reg(REG_WIDTH, 0);
        push_pixel(16'h1234, 1'b1);
        push_pixel('1, 1'b0);
        push_pixel('0, 1'b0);
        push_pixel(16'h8001, 1'b0);
        wait_for_tiles();
        program_reg(REG_SCALE, 3);
        program_reg(REG_WIDTH, 2);
        push_pixel(16'h0001, 1'b1);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hfffe, 1'b0);
        push_pixel(16'h0002, 1'b0);
        wait_for_tiles();
    endtask

    // A frame start in the middle of a row puts the position back to the origin.
    task automatic test_frame_restart();
        program_reg(REG_SCALE, 2);
        program_reg(REG_MODE, MODE_NEAREST);
        program_reg(REG_WIDTH, 4);
        for (int i = 0; i < 6; i++)
            push_pixel(rand_pixel(), i == 0);
        for (int i = 0; i < 6; i++)
            push_pixel(rand_pixel(), i == 0);
        wait_for_tiles();
    endtask

    // The width is cut below the current column half-way through a row: the next
    // pixel must end the row.
    task automatic test_width_cut();
        program_reg(REG_SCALE, 1);
        program_reg(REG_WIDTH, 10);
        for (int i = 0; i < 16; i++)
            push_pixel(rand_pixel(), i == 0);
        wait_for_tiles();
        program_reg(REG_WIDTH, 4);
        for (int i = 0; i < 6; i++)
            push_pixel(rand_pixel(), 1'b0);
        wait_for_tiles();
    endtask

    // Frames of random content under random settings. Small factors and narrow rows
    // dominate so that most pixels close a tile; a few frames use the largest factors
    // and out-of-range values. Stray frame starts and pauses until the output has
    // drained are mixed in.
    task automatic test_random_frames(input int item_count, input int src_pct,
                                      input int snk_pct);
        int sent, frame_len, roll;
        src_idle = src_pct;
        snk_idle = snk_pct;
        sent     = 0;
        while (sent < item_count)
        begin
            wait_for_tiles();
            roll = $urandom_range(99);
            if (roll < 60)
                program_reg(REG_SCALE, $urandom_range(3, 1));
            else if (roll < 80)
                program_reg(REG_SCALE, $urandom_range(6, 4));
            else if (roll < 90)
                program_reg(REG_SCALE, $urandom_range(8, 7));
            else
                program_reg(REG_SCALE, $urandom_range((1 << FACTOR_REG_BITS) - 1, 0));
            program_reg(REG_MODE, $urandom_range(1, 0) ? MODE_BILINEAR : MODE_NEAREST);
            roll = $urandom_range(99);
            if (roll < 70)
                program_reg(REG_WIDTH, $urandom_range(6, 2));
            else if (roll < 90)
                program_reg(REG_WIDTH, $urandom_range(24, 7));
            else
                program_reg(REG_WIDTH, $urandom_range(1, 0));
            frame_len = $urandom_range(30, 8);
            for (int i = 0; i < frame_len; i++)
            begin
                push_pixel(rand_pixel(), (i == 0) || ($urandom_range(99) < 3));
                sent++;
                if ($urandom_range(99) < 4)
                    wait_for_tiles();
            end
        end
        wait_for_tiles();
    endtask

    // Every output transfer is checked field by field against the oldest prediction.
    // The same process decides the receiver's readiness for the next cycle.
    always @(posedge clk)
    begin : result_check
        out_px_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_px.size() == 0)
                report_mismatch("transfer with nothing expected", '0, 64'(m_tdata));
            else
            begin
                want = pending_px.pop_front();
                if (m_tdata[PIX_W-1:0] !== want.value)
                    report_mismatch("out_value", 64'(want.value), 64'(m_tdata[PIX_W-1:0]));
                if (m_tdata[ROW_LSB +: COORD_BITS] !== want.row)
                    report_mismatch("out_row", 64'(want.row),
                                    64'(m_tdata[ROW_LSB +: COORD_BITS]));
                if (m_tdata[COL_LSB +: COORD_BITS] !== want.col)
                    report_mismatch("out_col", 64'(want.col),
                                    64'(m_tdata[COL_LSB +: COORD_BITS]));
                if (m_tlast !== want.last)
                    report_mismatch("tile_last", 64'(want.last), 64'(m_tlast));
            end
        end
        m_tready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // The sequence of tests. Idling starts with a hesitant sender and a very hesitant
    // receiver, swaps the two, and finishes with both running flat out.
    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle = 30;
        snk_idle = 59;
        test_register_reset();
        test_corner_pixels();
        test_factor_limits();
        test_frame_restart();
        test_width_cut();
        test_random_frames(64, 30, 59);
        test_random_frames(64, 59, 30);
        test_random_frames(64, 0, 0);
        wait_for_tiles();
        if (mismatches == 0 && pending_px.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
